>>> src/hkt_pkg.sv
`default_nettype none
package hkt_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int KEY_W     = 4;
	localparam int TIME_W    = 32;
	localparam int SLOT_W    = 3;
	localparam int CNTF_W    = 4;
	localparam int TDATA_W   = 48;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_FIND   = 3'd1,
		OP_GET    = 3'd2,
		OP_REMOVE = 3'd3,
		OP_REPACK = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_LOAD,
		ACT_SHIFT,
		ACT_SCRUB
	} cell_act_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_PACK,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] ptime;
		logic [KEY_W-1:0]  col;
		logic [KEY_W-1:0]  row;
	} entry_t;

	typedef struct packed {
		cell_act_t act;
		entry_t    key;
	} cell_cmd_t;

	// packed from the top down: ok ends up in bit 0
	typedef struct packed {
		logic [CNTF_W-1:0] entries;
		logic [TIME_W-1:0] hit_time;
		logic [KEY_W-1:0]  hit_col;
		logic [KEY_W-1:0]  hit_row;
		logic [SLOT_W-1:0] hit_slot;
		logic              ok;
	} result_t;

endpackage
`default_nettype wire

>>> src/hkt_cell.sv
`default_nettype none
module hkt_cell import hkt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_cmd_t        cmd,
	input  wire logic [IDX_W-1:0] pos,
	input  wire logic [IDX_W-1:0] idx,
	input  wire entry_t           nxt,
	output entry_t                ent,
	output logic                  match,
	output logic                  empty
);

	entry_t ent_q;
	entry_t ent_d;

	always_comb begin
		ent_d = ent_q;
		case (cmd.act)
			ACT_LOAD: begin
				if (pos == idx) begin
					ent_d = cmd.key;
				end
			end
			ACT_SHIFT: begin
				if (idx >= pos) begin
					ent_d = nxt;
				end
			end
			ACT_SCRUB: begin
				if (ent_q.ptime == '0) begin
					ent_d.row = '0;
					ent_d.col = '0;
				end
			end
			default: begin
				ent_d = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

	assign ent   = ent_q;
	assign empty = (ent_q.ptime == '0);
	assign match = (ent_q.row == cmd.key.row) && (ent_q.col == cmd.key.col);

endmodule
`default_nettype wire

>>> src/hkt_ctrl.sv
`default_nettype none
module hkt_ctrl import hkt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [TDATA_W-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [TDATA_W-1:0]       m_tdata,
	input  wire entry_t [DEPTH-1:0]  ent,
	input  wire logic [DEPTH-1:0]    match,
	input  wire logic [DEPTH-1:0]    empty,
	output cell_cmd_t                cell_cmd,
	output logic [IDX_W-1:0]         cell_pos
);

	state_t               state_q, state_d;
	op_t                  op_q;
	entry_t               key_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [DEPTH-1:0]     stop_q, hitv_q;
	logic [IDX_W-1:0]     pass_q, pass_d;
	result_t              out_q, res;
	logic                 out_valid_q;

	logic                 out_free, out_load, cap_find;
	logic [IDX_W-1:0]     fe_idx, stop_idx, slot_idx, rd_idx;
	logic                 any_empty, any_stop, slot_in_depth, slot_in_count;
	cell_act_t            act;
	entry_t               rd_ent;

	// first empty cell and first stopping cell
	always_comb begin
		fe_idx   = '0;
		stop_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (empty[i]) begin
				fe_idx = IDX_W'(i);
			end
			if (stop_q[i]) begin
				stop_idx = IDX_W'(i);
			end
		end
	end

	assign any_empty     = |empty;
	assign any_stop      = |stop_q;
	assign slot_idx      = IDX_W'(slot_q);
	assign slot_in_depth = (32'(slot_q) < DEPTH);
	assign slot_in_count = (32'(slot_q) < 32'(count_q));
	assign rd_idx        = (op_q == OP_FIND) ? stop_idx : slot_idx;
	assign rd_ent        = ent[rd_idx];
	assign out_free      = !out_valid_q || m_tready;
	assign s_tready      = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		pass_d   = pass_q;
		act      = ACT_HOLD;
		cell_pos = '0;
		res      = '0;
		out_load = 1'b0;
		cap_find = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cap_find = 1'b1;
				pass_d   = '0;
				if (op_q == OP_REPACK) begin
					act     = ACT_SCRUB;
					state_d = ST_PACK;
				end else begin
					state_d = ST_EXEC;
				end
			end
			ST_PACK: begin
				// each pass squeezes out the first empty cell
				if (any_empty) begin
					act      = ACT_SHIFT;
					cell_pos = fe_idx;
				end
				pass_d = pass_q + 1'b1;
				if (pass_q == IDX_W'(DEPTH - 2)) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					case (op_q)
						OP_ADD: begin
							if (32'(count_q) < DEPTH) begin
								act          = ACT_LOAD;
								cell_pos     = IDX_W'(count_q);
								count_d      = CNT_W'(count_q + 1'b1);
								res.ok       = 1'b1;
								res.hit_slot = SLOT_W'(count_q);
								res.hit_row  = key_q.row;
								res.hit_col  = key_q.col;
								res.hit_time = key_q.ptime;
							end
						end
						OP_FIND: begin
							if (any_stop && hitv_q[stop_idx]) begin
								res.ok       = 1'b1;
								res.hit_slot = SLOT_W'(stop_idx);
								res.hit_row  = rd_ent.row;
								res.hit_col  = rd_ent.col;
								res.hit_time = rd_ent.ptime;
							end
						end
						OP_GET: begin
							if (slot_in_depth) begin
								res.ok       = 1'b1;
								res.hit_slot = slot_q;
								res.hit_row  = rd_ent.row;
								res.hit_col  = rd_ent.col;
								res.hit_time = rd_ent.ptime;
							end
						end
						OP_REMOVE: begin
							if (slot_in_count && slot_in_depth) begin
								act          = ACT_SHIFT;
								cell_pos     = slot_idx;
								count_d      = CNT_W'(count_q - 1'b1);
								res.ok       = 1'b1;
								res.hit_slot = slot_q;
								res.hit_row  = rd_ent.row;
								res.hit_col  = rd_ent.col;
								res.hit_time = rd_ent.ptime;
							end
						end
						OP_REPACK: begin
							count_d = any_empty ? CNT_W'(fe_idx) : CNT_W'(DEPTH);
						end
						default: begin
							count_d = count_q;
						end
					endcase
					res.entries = CNTF_W'(count_d);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign cell_cmd.act = act;
	assign cell_cmd.key = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pass_q  <= pass_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q      <= op_t'(s_tdata[2:0]);
			key_q.row <= s_tdata[6:3];
			key_q.col <= s_tdata[10:7];
			key_q.ptime <= s_tdata[42:11];
			slot_q    <= s_tdata[45:43];
		end
		if (cap_find) begin
			stop_q <= match | empty;
			hitv_q <= match & ~empty;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("entry count beyond table depth");

	a_count_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_EXEC |=> $stable(count_q))
		else $error("entry count changed outside execute");

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && op_q == OP_ADD && res.ok |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("accepted add did not bump the count");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_EXEC)
		else $error("result raised outside execute");

endmodule
`default_nettype wire

>>> src/held_key_table.sv
// Held key table: TABLE_DEPTH cells in a row, each holding one key (row, column,
// press time; time zero means empty). One transaction on the s_ side carries one
// command, one transaction on the m_ side returns its result. For add, find, get
// and remove the result goes through the prepare and execute states after
// acceptance; repack adds a pack state between them, in which each pass of the
// cell row squeezes out one empty slot and the row needs TABLE_DEPTH - 1 passes.
// Commands are handled one at a time; the next one is accepted as soon as the
// current result sits in the output register, and acceptance waits longer while
// the output stalls.
`default_nettype none
module held_key_table import hkt_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// op[2:0], key_row[6:3], key_col[10:7], press_time[42:11], slot[45:43]
	input  wire logic [TDATA_W-1:0] s_tdata,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// ok[0], hit_slot[3:1], hit_row[7:4], hit_col[11:8], hit_time[43:12], entries[47:44]
	output logic [TDATA_W-1:0]      m_tdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	entry_t [TABLE_DEPTH-1:0] ent;
	entry_t [TABLE_DEPTH-1:0] nxt;
	logic   [TABLE_DEPTH-1:0] match;
	logic   [TABLE_DEPTH-1:0] empty;
	cell_cmd_t                cell_cmd;
	logic   [IDX_W-1:0]       cell_pos;

	hkt_ctrl #(
		.DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.ent      (ent),
		.match    (match),
		.empty    (empty),
		.cell_cmd (cell_cmd),
		.cell_pos (cell_pos)
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign nxt[i] = '0;
		end else begin : g_link
			assign nxt[i] = ent[i + 1];
		end

		hkt_cell #(
			.DEPTH(TABLE_DEPTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cell_cmd),
			.pos    (cell_pos),
			.idx    (IDX_W'(i)),
			.nxt    (nxt[i]),
			.ent    (ent[i]),
			.match  (match[i]),
			.empty  (empty[i])
		);
	end

endmodule
`default_nettype wire
